@@ sv/etcd_pkg.sv @@
package etcd_pkg;

    localparam int EPOCH_W   = 32;
    localparam int PROD_W    = 2 * EPOCH_W;
    localparam int DAYS_W    = 16;
    localparam int YEAR_W    = 8;
    localparam int DOY_W     = 9;
    localparam int MON_W     = 4;
    localparam int REM_W     = 6;
    localparam int OUT_W     = 48;

    localparam logic [YEAR_W-1:0] BASE_YEAR_OFS = 8'd70;   // 1970 - 1900
    localparam logic [MON_W-1:0]  LAST_MONTH    = 4'd11;
    localparam logic [MON_W-1:0]  FEB           = 4'd1;
    localparam logic [EPOCH_W-1:0] WDAY_OFS     = 32'd4;   // 1970-01-01 was a Thursday

    // reciprocals for exact unsigned division by multiply and shift
    localparam logic [EPOCH_W-1:0] RECIP_15 = 32'h8888_8889;   // ceil(2^35 / 15)
    localparam logic [EPOCH_W-1:0] RECIP_3  = 32'hAAAA_AAAB;   // ceil(2^33 / 3)
    localparam logic [EPOCH_W-1:0] RECIP_7  = 32'h2492_4925;   // ceil(2^32 / 7), day counts only

    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_WDAY
    } t_div_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIV_END,
        S_YEAR,
        S_MONTH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    div_store;
        t_div_op div_op;
        logic    year_step;
        logic    month_init;
        logic    month_step;
    } t_dp_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_sts;

    function automatic logic [REM_W-1:0] div_const(input t_div_op op);
        logic [REM_W-1:0] d;
        unique case (op)
            DIV_SEC:  d = 6'd60;
            DIV_MIN:  d = 6'd60;
            DIV_HOUR: d = 6'd24;
            DIV_WDAY: d = 6'd7;
            default:  d = 6'd60;
        endcase
        return d;
    endfunction

    // year given as offset from 1900; centuries in reach are 1900, 2000, 2100
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200);
    endfunction

    function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] l;
        case (m)
            4'd0:    l = 5'd31;
            4'd1:    l = leap ? 5'd29 : 5'd28;
            4'd2:    l = 5'd31;
            4'd3:    l = 5'd30;
            4'd4:    l = 5'd31;
            4'd5:    l = 5'd30;
            4'd6:    l = 5'd31;
            4'd7:    l = 5'd31;
            4'd8:    l = 5'd30;
            4'd9:    l = 5'd31;
            4'd10:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

@@ sv/etcd_datapath.sv @@
module etcd_datapath (
    input  logic                          i_clk,
    input  etcd_pkg::t_dp_cmd             i_cmd,
    input  logic [etcd_pkg::EPOCH_W-1:0]  i_epoch,
    output etcd_pkg::t_dp_sts             o_sts,
    output logic [etcd_pkg::OUT_W-1:0]    o_result
);
    import etcd_pkg::*;

    logic [EPOCH_W-1:0] r_quo;
    logic [EPOCH_W-1:0] r_q,    n_q;
    logic [REM_W-1:0]   r_sec,  r_min;
    logic [4:0]         r_hour;
    logic [2:0]         r_wday;
    logic [DAYS_W-1:0]  r_days;
    logic [YEAR_W-1:0]  r_year;
    logic [DOY_W-1:0]   r_mrem;
    logic [MON_W-1:0]   r_mon;

    logic [EPOCH_W-1:0]   mul_in;
    logic [EPOCH_W-1:0]   recip;
    logic [PROD_W-1:0]    product;
    logic [REM_W-1:0]     divisor;
    logic [REM_W-1:0]     rem;
    logic                 leap;
    logic [DOY_W-1:0]     year_len;
    logic [4:0]           mlen;

    always_comb begin
        // /60 as (x >> 2) / 15, /24 as (x >> 3) / 3
        case (i_cmd.div_op) inside
            DIV_SEC, DIV_MIN: begin
                mul_in = {2'b00, r_quo[EPOCH_W-1:2]};
                recip  = RECIP_15;
            end
            DIV_HOUR: begin
                mul_in = {3'b000, r_quo[EPOCH_W-1:3]};
                recip  = RECIP_3;
            end
            default: begin
                mul_in = r_quo;
                recip  = RECIP_7;
            end
        endcase
        product = mul_in * recip;
        case (i_cmd.div_op) inside
            DIV_SEC, DIV_MIN: n_q = {3'b000, product[PROD_W-1:35]};
            DIV_HOUR:         n_q = {1'b0, product[PROD_W-1:33]};
            default:          n_q = product[PROD_W-1:32];
        endcase
        // remainder is below the divisor, so the low bits are exact
        divisor  = div_const(i_cmd.div_op);
        rem      = r_quo[REM_W-1:0] - REM_W'(r_q[REM_W-1:0] * divisor);
        leap     = is_leap(r_year);
        year_len = leap ? 9'd366 : 9'd365;
        mlen     = month_len(r_mon, leap);
        o_sts.year_done  = r_days < DAYS_W'(year_len);
        o_sts.month_done = (r_mon == LAST_MONTH) || (r_mrem < DOY_W'(mlen));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= i_epoch;
        end else if (i_cmd.div_step) begin
            r_q <= n_q;
        end else if (i_cmd.div_store) begin
            case (i_cmd.div_op)
                DIV_SEC: begin
                    r_sec <= rem;
                    r_quo <= r_q;
                end
                DIV_MIN: begin
                    r_min <= rem;
                    r_quo <= r_q;
                end
                DIV_HOUR: begin
                    r_hour <= rem[4:0];
                    r_days <= r_q[DAYS_W-1:0];
                    r_quo  <= r_q + WDAY_OFS;
                end
                default: begin
                    r_wday <= rem[2:0];
                    r_year <= BASE_YEAR_OFS;
                end
            endcase
        end

        if (i_cmd.year_step && !o_sts.year_done) begin
            r_days <= r_days - DAYS_W'(year_len);
            r_year <= r_year + 1'b1;
        end

        if (i_cmd.month_init) begin
            r_mrem <= r_days[DOY_W-1:0];
            r_mon  <= '0;
        end else if (i_cmd.month_step && !o_sts.month_done) begin
            r_mrem <= r_mrem - DOY_W'(mlen);
            r_mon  <= r_mon + 1'b1;
        end
    end

    logic [4:0] dom;
    assign dom = r_mrem[4:0] + 5'd1;

    assign o_result = {2'b00, dom, r_mon, r_days[DOY_W-1:0], r_year,
                       r_wday, r_hour, r_min, r_sec};

endmodule

@@ sv/etcd_ctrl.sv @@
module etcd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  etcd_pkg::t_dp_sts  i_sts,
    output etcd_pkg::t_dp_cmd  o_cmd
);
    import etcd_pkg::*;

    t_state              r_state, n_state;
    t_div_op             r_op,    n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= DIV_SEC;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd       = '0;
        o_cmd.div_op = r_op;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = DIV_SEC;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DIV_END;
            end
            S_DIV_END: begin
                o_cmd.div_store = 1'b1;
                unique case (r_op)
                    DIV_SEC:  begin n_op = DIV_MIN;  n_state = S_DIV; end
                    DIV_MIN:  begin n_op = DIV_HOUR; n_state = S_DIV; end
                    DIV_HOUR: begin n_op = DIV_WDAY; n_state = S_DIV; end
                    default:  n_state = S_YEAR;
                endcase
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    o_cmd.month_init = 1'b1;
                    n_state          = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ sv/epoch_to_calendar_date.sv @@
// Converts seconds since 1970-01-01 00:00:00 UTC into UTC calendar fields.
// Input stream: one beat carries a 32-bit unsigned epoch count in tdata.
// Output stream: one beat per input, tdata packs second, minute, hour,
// weekday, year since 1900, day of year, month and day of month.
// Steps per beat: four divisions by reciprocal multiply
// (/60, /60, /24, then weekday mod 7), then year stepping over the
// whole years since 1970 (0..136), then month stepping up to the
// month index (0..11), then the result.
// One conversion is in flight at a time: s_axis tready is high only while
// the block is idle, so a new beat is accepted only after the previous
// result has been taken on the output side.
// The result is held stable on m_axis until taken; while the receiver
// stalls, no new input is accepted.
// Synchronous active-low reset returns the controller to idle, with no
// output beat pending; no data registers are cleared.
module epoch_to_calendar_date (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [31:0] epoch_seconds
    input  logic [etcd_pkg::EPOCH_W-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] year_since_1900, [36:28] day_of_year, [40:37] month_index,
    // [45:41] day_of_month, [47:46] zero
    output logic [etcd_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import etcd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    etcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    etcd_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_epoch  (i_s_axis_tdata),
        .o_sts    (sts),
        .o_result (o_m_axis_tdata)
    );

endmodule
